// ===== rtl/core/ptcd_pkg.sv =====
// Shared types, constants and helpers of the PWM temperature chain decoder.
`default_nettype none
package ptcd_pkg;

    localparam int LINES_DEF     = 5;
    localparam int MAX_EDGES_DEF = 16;
    localparam int NUM_EXP_REGS  = 5;
    localparam int CNT_W         = 5;
    localparam int IDX_W         = CNT_W + 2;
    localparam int LINE_W        = 3;
    localparam int TS_W          = 32;
    localparam int TEMP_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int SLOPE_W       = 10;
    localparam int DVD_W         = TS_W + SLOPE_W;
    localparam int DIV_CNT_W     = 6;

    localparam logic [SLOPE_W-1:0]   C_SLOPE   = SLOPE_W'(751);
    localparam logic [DVD_W-1:0]     C_OFFSET  = DVD_W'(421);
    localparam logic [DVD_W-1:0]     C_SAT_SUB = DVD_W'(421 + 32768);
    localparam logic [TEMP_W-1:0]    C_SAT_VAL = 16'h8000;
    localparam logic [TEMP_W-1:0]    LIMIT_RST = TEMP_W'(60);

    localparam logic [CFG_IDX_W-1:0] REG_DANGER = 3'd5;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic                func;
        logic [LINE_W-1:0]   line;
        logic [TS_W-1:0]     timestamp;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0]         sensor_index;
        logic signed [TEMP_W-1:0] temperature;
        logic                     zero_interval;
        logic                     over_limit;
        logic [TEMP_W-1:0]        error_mask;
    } t_out;

    typedef struct packed {
        logic             close;
        logic             zero;
        logic [TS_W-1:0]  th;
        logic [TS_W-1:0]  tl;
        logic [IDX_W-1:0] idx;
    } t_pair;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic t_cnt exp_reset(input int i);
        t_cnt v;
        case (i)
            0:       v = 5'd9;
            1:       v = 5'd7;
            2:       v = 5'd7;
            3:       v = 5'd9;
            4:       v = 5'd5;
            default: v = 5'd1;
        endcase
        return v;
    endfunction

    function automatic t_cnt pairs_of(input t_cnt e);
        t_cnt v;
        v = (e == '0) ? '0 : ((e - 5'd1) >> 1);
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ptcd_div.sv =====
// Bit-serial restoring divider: (751 * high) / low, one quotient bit per cycle.
`default_nettype none
module ptcd_div
    import ptcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [TS_W-1:0]  i_th,
    input  wire logic [TS_W-1:0]  i_tl,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quot,
    output logic [TS_W-1:0]       o_rem
);

    logic [DVD_W-1:0]     r_dvd;
    logic [TS_W-1:0]      r_dvs;
    logic [TS_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [TS_W:0]        shifted;
    logic [TS_W+1:0]      diff;
    logic                 qbit;
    logic [TS_W-1:0]      n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[DVD_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        qbit    = !diff[TS_W+1];
        n_rem   = qbit ? diff[TS_W-1:0] : shifted[TS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DVD_W'(C_SLOPE) * DVD_W'(i_th);
            r_dvs <= i_tl;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== rtl/core/ptcd_lines.sv =====
// Per-line edge counters, previous edges and high intervals; pair detection.
`default_nettype none
module ptcd_lines
    import ptcd_pkg::*;
#(
    parameter int LINES     = LINES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_in   i_in,
    input  wire t_cnt  i_exp [LINES],
    output t_pair      o_pair
);

    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

    t_cnt             r_cnt  [LINES];
    logic [TS_W-1:0]  r_prev [LINES];
    logic [TS_W-1:0]  r_high [LINES];

    t_cnt             eff  [LINES];
    logic [IDX_W-1:0] base [LINES];
    logic [IDX_W-1:0] acc;
    logic [LW-1:0]    sel;
    logic             line_ok;
    logic             take;
    t_cnt             c;
    logic [TS_W-1:0]  delta;

    always_comb begin
        acc = '0;
        for (int i = 0; i < LINES; i++) begin
            eff[i]  = ({1'b0, i_exp[i]} > (CNT_W+1)'(MAX_EDGES)) ? CNT_W'(MAX_EDGES) : i_exp[i];
            base[i] = acc;
            acc     = acc + IDX_W'(pairs_of(eff[i]));
        end
    end

    always_comb begin
        line_ok = 32'(i_in.line) < LINES;
        sel     = LW'(i_in.line);
        c       = line_ok ? r_cnt[sel] : '0;
        take    = i_in.func && line_ok && (c < (line_ok ? eff[sel] : '0));
        delta   = i_in.timestamp - (line_ok ? r_prev[sel] : '0);
        o_pair.th    = line_ok ? r_high[sel] : '0;
        o_pair.tl    = delta;
        o_pair.close = take && !c[0];
        o_pair.zero  = (o_pair.th == '0) || (delta == '0);
        o_pair.idx   = IDX_W'((c - 5'd2) >> 1) + (line_ok ? base[sel] : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                r_cnt[i]  <= 5'd1;
                r_prev[i] <= '0;
                r_high[i] <= '0;
            end
        end else if (i_accept) begin
            if (!i_in.func) begin
                for (int i = 0; i < LINES; i++) begin
                    r_cnt[i]  <= 5'd1;
                    r_prev[i] <= '0;
                    r_high[i] <= '0;
                end
            end else if (take) begin
                r_prev[sel] <= i_in.timestamp;
                r_cnt[sel]  <= c + 5'd1;
                if (c[0]) begin
                    r_high[sel] <= delta;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pwm_temperature_chain_decoder_core.sv =====
// Top level: config registers, sequencer, decode and output register.
// Sequence: an edge that closes a pair registers its intervals, forms the product in ST_MUL,
// runs the bit-serial divide in ST_DIV, then decodes into the output register from ST_DONE once
// it is free; a zero-interval pair goes straight to ST_DONE. Other edges and start items give no
// result. One item at a time: a closing pair holds the input until its result is loaded.
// Reset (synchronous, active low) restores register defaults and clears all line state.
`default_nettype none
module pwm_temperature_chain_decoder_core
    import ptcd_pkg::*;
#(
    parameter int LINES     = LINES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in                    i_in,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out                        o_out,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_state               r_state, n_state;
    t_cnt                 r_exp [NUM_EXP_REGS];
    logic [TEMP_W-1:0]    r_limit;
    logic [TEMP_W-1:0]    r_sticky, n_sticky;
    logic [TS_W-1:0]      r_th, r_tl;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_zero;
    logic                 r_out_valid;
    t_out                 r_out, n_out;

    t_cnt                 line_exp [LINES];
    t_pair                pair;
    logic                 in_acc;
    logic                 div_start;
    logic                 div_done;
    logic [DVD_W-1:0]     quot;
    logic [TS_W-1:0]      rem;
    logic                 out_load;
    logic                 quot_low;
    logic [DVD_W-1:0]     sub;
    logic [TEMP_W-1:0]    temp;
    logic                 over;

    for (genvar g = 0; g < LINES; g++) begin : g_exp
        if (g < NUM_EXP_REGS) begin : g_reg
            assign line_exp[g] = r_exp[g];
        end else begin : g_fix
            assign line_exp[g] = 5'd1;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_EXP_REGS; i++) begin
                r_exp[i] <= exp_reset(i);
            end
            r_limit <= LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_DANGER) begin
                r_limit <= i_cfg_data;
            end else if (32'(i_cfg_index) < NUM_EXP_REGS) begin
                r_exp[i_cfg_index] <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    ptcd_lines #(
        .LINES     (LINES),
        .MAX_EDGES (MAX_EDGES)
    ) u_lines (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_in     (i_in),
        .i_exp    (line_exp),
        .o_pair   (pair)
    );

    ptcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_th    (r_th),
        .i_tl    (r_tl),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_rem   (rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && pair.close) begin
                    n_state = pair.zero ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        div_start  = (r_state == ST_MUL);
        out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        quot_low = (quot < C_OFFSET) || ((quot == C_OFFSET) && (rem == '0));
        sub      = quot + DVD_W'(quot_low && (rem != '0));
        if (r_zero) begin
            temp = '0;
        end else if (sub >= C_SAT_SUB) begin
            temp = C_SAT_VAL;
        end else begin
            temp = TEMP_W'(C_OFFSET) - sub[TEMP_W-1:0];
        end
        over     = !r_zero && ($signed(temp) > $signed(r_limit));
        n_sticky = r_sticky;
        if (over && (r_idx < IDX_W'(TEMP_W))) begin
            n_sticky[r_idx[CNT_W-2:0]] = 1'b1;
        end
        n_out.sensor_index  = r_idx[CNT_W-1:0];
        n_out.temperature   = temp;
        n_out.zero_interval = r_zero;
        n_out.over_limit    = over;
        n_out.error_mask    = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sticky    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && !i_in.func) begin
                r_sticky <= '0;
            end else if (out_load) begin
                r_sticky <= n_sticky;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && pair.close) begin
            r_th   <= pair.th;
            r_tl   <= pair.tl;
            r_idx  <= pair.idx;
            r_zero <= pair.zero;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside of the divide state");

    a_pair_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && pair.close && !pair.zero) |=> r_state == ST_MUL)
        else $error("closed pair did not start the product cycle");

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |=> r_state == ST_DIV)
        else $error("product cycle not followed by divide");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.zero_interval) |->
            (!r_out.over_limit && r_out.temperature == '0))
        else $error("zero-interval result carries a temperature or limit flag");

endmodule
`default_nettype wire
